/* src/tttr_pkg.sv */
package tttr_pkg;

    localparam int REC_W   = 32;
    localparam int TIME_W  = 64;
    localparam int CH_W    = 6;
    localparam int IDX_W   = 32;
    localparam int OPND_W  = 50;
    localparam int MICRO_W = 15;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_MODE    = 2'd1;

    localparam logic       DEV_SIX_CH  = 1'b0;
    localparam logic       DEV_FOUR_CH = 1'b1;
    localparam logic [1:0] TAG_T2      = 2'd2;
    localparam logic [1:0] TAG_T3      = 2'd3;

    localparam logic [5:0]        CH6_OVERFLOW  = 6'd63;
    localparam logic [3:0]        CH4_OVERFLOW  = 4'd15;
    localparam logic [3:0]        CH4_LAST_PH   = 4'd4;
    localparam logic [3:0]        CH4_FIRST_T3  = 4'd1;
    localparam logic [OPND_W-1:0] INC_FOUR_T2   = OPND_W'(210698240);
    localparam logic [OPND_W-1:0] INC_FOUR_T3   = OPND_W'(65536);
    localparam logic [IDX_W-1:0]  IDX_MAX       = '1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [REC_W-1:0] record;
        logic             end_of_block;
    } t_req;

    typedef struct packed {
        logic [TIME_W-1:0] photon_time;
        logic [TIME_W-1:0] sync_count;
        logic [CH_W-1:0]   channel;
        logic [IDX_W-1:0]  photon_index;
    } t_res;

    typedef enum logic [1:0] {
        KIND_NOP,
        KIND_PHOTON,
        KIND_OVERFLOW
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic               eob;
        logic               t3;
        logic [OPND_W-1:0]  operand;
        logic [MICRO_W-1:0] micro;
        logic [CH_W-1:0]    channel;
    } t_op;

endpackage

/* src/tttr_record_decoder_unit.sv */
// Time-tagged record decoder: accepts one 32-bit counter record per cycle unless
// o_in_stall is high, and returns a result only for photon records (overflow
// and other records update state or are dropped). The front decodes each record
// against the configured format and tag mode and hands it to a four-entry queue;
// the back applies it with one 64-bit adder into a result register, one record
// per cycle while not stalled. Write device_kind and tag_mode only while idle.
module tttr_record_decoder_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tttr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tttr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  tttr_pkg::t_req                    i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output tttr_pkg::t_res                    o_out_res
);
    import tttr_pkg::*;

    t_op  front_op;
    t_op  q_op;
    logic q_valid;
    logic q_full;
    logic q_pop;

    assign o_in_stall = q_full;

    tttr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_in_req),
        .o_op       (front_op)
    );

    tttr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_op    (front_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    tttr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_op        (q_op),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res),
        .i_out_stall (i_out_stall)
    );

endmodule

/* src/tttr_front.sv */
module tttr_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tttr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tttr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  tttr_pkg::t_req                    i_req,
    output tttr_pkg::t_op                     o_op
);
    import tttr_pkg::*;

    logic             r_dev;
    logic [1:0]       r_mode;
    logic [REC_W-1:0] rec;
    logic [24:0]      k25;
    logic [9:0]       k10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev  <= DEV_SIX_CH;
            r_mode <= TAG_T2;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_DEVICE_KIND) begin
                r_dev <= i_cfg_data[0];
            end else if (i_cfg_idx == CFG_TAG_MODE) begin
                r_mode <= i_cfg_data[1:0];
            end
        end
    end

    assign rec = i_req.record;
    // overflow counts of zero still advance by one unit
    assign k25 = rec[24:0] | {24'b0, (rec[24:0] == 25'd0)};
    assign k10 = rec[9:0] | {9'b0, (rec[9:0] == 10'd0)};

    always_comb begin
        o_op         = '0;
        o_op.kind    = KIND_NOP;
        o_op.eob     = i_req.end_of_block;
        o_op.t3      = (r_mode == TAG_T3);
        if (r_dev == DEV_SIX_CH) begin
            o_op.channel = rec[30:25];
            case (r_mode)
                TAG_T2: begin
                    if (!rec[31]) begin
                        o_op.kind    = KIND_PHOTON;
                        o_op.operand = OPND_W'(rec[24:0]);
                    end else if (rec[30:25] == CH6_OVERFLOW) begin
                        o_op.kind    = KIND_OVERFLOW;
                        o_op.operand = {k25, 25'b0};
                    end
                end
                TAG_T3: begin
                    o_op.micro = rec[24:10];
                    if (!rec[31]) begin
                        o_op.kind    = KIND_PHOTON;
                        o_op.operand = OPND_W'(rec[9:0]);
                    end else if (rec[30:25] == CH6_OVERFLOW) begin
                        o_op.kind    = KIND_OVERFLOW;
                        o_op.operand = OPND_W'({k10, 10'b0});
                    end
                end
                default: o_op.kind = KIND_NOP;
            endcase
        end else begin
            o_op.channel = CH_W'(rec[31:28]);
            case (r_mode)
                TAG_T2: begin
                    if (rec[31:28] <= CH4_LAST_PH) begin
                        o_op.kind    = KIND_PHOTON;
                        o_op.operand = OPND_W'(rec[27:0]);
                    end else if (rec[31:28] == CH4_OVERFLOW && rec[3:0] == 4'd0) begin
                        o_op.kind    = KIND_OVERFLOW;
                        o_op.operand = INC_FOUR_T2;
                    end
                end
                TAG_T3: begin
                    o_op.micro = MICRO_W'(rec[27:16]);
                    if (rec[31:28] >= CH4_FIRST_T3 && rec[31:28] <= CH4_LAST_PH) begin
                        o_op.kind    = KIND_PHOTON;
                        o_op.operand = OPND_W'(rec[15:0]);
                    end else if (rec[31:28] == CH4_OVERFLOW && rec[19:16] == 4'd0) begin
                        o_op.kind    = KIND_OVERFLOW;
                        o_op.operand = INC_FOUR_T3;
                    end
                end
                default: o_op.kind = KIND_NOP;
            endcase
        end
    end

endmodule

/* src/tttr_queue.sv */
module tttr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tttr_pkg::t_op  i_op,
    output logic           o_full,
    output logic           o_valid,
    output tttr_pkg::t_op  o_op,
    input  logic           i_pop
);
    import tttr_pkg::*;

    localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);
    localparam logic [Q_CNT_W-1:0] CNT_FULL = Q_CNT_W'(Q_DEPTH);

    t_op                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_count;
    logic               push;
    logic               pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count beyond depth");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not grow on push");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CNT_FULL) |-> r_wr == r_rd)
        else $error("queue pointers disagree with count");
`endif

endmodule

/* src/tttr_back.sv */
module tttr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  tttr_pkg::t_op  i_op,
    output logic           o_pop,
    output logic           o_out_valid,
    output tttr_pkg::t_res o_out_res,
    input  logic           i_out_stall
);
    import tttr_pkg::*;

    logic [TIME_W-1:0] r_base;
    logic [IDX_W-1:0]  r_cnt;
    logic              r_out_valid;
    t_res              r_res;
    logic [TIME_W-1:0] sum;
    logic              slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_pop       = i_valid && (i_op.kind != KIND_PHOTON || slot_free);
    assign sum         = r_base + TIME_W'(i_op.operand);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                unique case (i_op.kind)
                    KIND_PHOTON: begin
                        r_out_valid <= 1'b1;
                        if (r_cnt != IDX_MAX) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    KIND_OVERFLOW: r_base <= sum;
                    default: ;
                endcase
                if (i_op.eob) begin
                    r_cnt <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_op.kind == KIND_PHOTON) begin
            r_res.photon_time  <= i_op.t3 ? TIME_W'(i_op.micro) : sum;
            r_res.sync_count   <= i_op.t3 ? sum : '0;
            r_res.channel      <= i_op.channel;
            r_res.photon_index <= r_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_eob_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_op.eob |=> r_cnt == '0)
        else $error("photon index not cleared after end of block");
    a_photon_keeps_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_op.kind != KIND_OVERFLOW |=> $stable(r_base))
        else $error("base moved on a non-overflow request");
    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == IDX_MAX && !(o_pop && i_op.eob) |=> r_cnt == IDX_MAX)
        else $error("photon index wrapped");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_res))
        else $error("pending result overwritten");
`endif

endmodule

/* bench/tb_tttr_record_decoder_unit.sv */
module tb_tttr_record_decoder_unit;
    import tttr_pkg::*;

    localparam logic [63:0] STEP_FOUR_T2 = 64'd210698240;
    localparam logic [63:0] STEP_FOUR_T3 = 64'd65536;
    localparam logic [1:0] TAG_UNUSED_0 = 2'd0;
    localparam logic [1:0] TAG_UNUSED_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int QUIET_CYCLES = 4;
    localparam int BIG_OVF_RECORDS = 100;

    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_req                  req;
        bit                    typed;
        t_res                  want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_req                  i_in_req = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_res                  o_out_res;

    // predictor state and register copies
    logic        dev_kind = DEV_SIX_CH;
    logic [1:0]  tag_mode = TAG_T2;
    logic [63:0] ovf_base = '0;
    logic [31:0] ph_ctr = '0;

    t_res        photons_due[$];
    t_row        plan[$];
    bit          req_typed = 1'b0;
    t_res        req_want = '0;
    bit          in_fire = 1'b0;
    int unsigned mismatches = 0;
    int unsigned burst_left = 0;
    bit          gaps_on = 1'b1;
    logic [9:0]  stall_tick = '0;
    t_res        predicted;
    t_res        got;
    t_res        want;

    tttr_record_decoder_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic bit decode_record(input t_req rq, output t_res res);
        logic [31:0] r;
        logic [63:0] ptime;
        logic [63:0] scount;
        logic [5:0]  ch;
        bit          photon;
        r = rq.record;
        ptime = '0;
        scount = '0;
        photon = 1'b0;
        if (dev_kind == DEV_SIX_CH) begin
            ch = r[30:25];
            if (tag_mode == TAG_T2) begin
                if (!r[31]) begin
                    photon = 1'b1;
                    ptime = ovf_base + 64'(r[24:0]);
                end else if (ch == CH6_OVERFLOW) begin
                    ovf_base += 64'(r[24:0] == '0 ? 25'd1 : r[24:0]) << 25;
                end
            end else if (tag_mode == TAG_T3) begin
                if (!r[31]) begin
                    photon = 1'b1;
                    ptime = 64'(r[24:10]);
                    scount = ovf_base + 64'(r[9:0]);
                end else if (ch == CH6_OVERFLOW) begin
                    ovf_base += 64'(r[9:0] == '0 ? 10'd1 : r[9:0]) << 10;
                end
            end
        end else begin
            ch = {2'b00, r[31:28]};
            if (tag_mode == TAG_T2) begin
                if (r[31:28] <= CH4_LAST_PH) begin
                    photon = 1'b1;
                    ptime = ovf_base + 64'(r[27:0]);
                end else if (r[31:28] == CH4_OVERFLOW && r[3:0] == '0) begin
                    ovf_base += STEP_FOUR_T2;
                end
            end else if (tag_mode == TAG_T3) begin
                if (r[31:28] >= CH4_FIRST_T3 && r[31:28] <= CH4_LAST_PH) begin
                    photon = 1'b1;
                    ptime = 64'(r[27:16]);
                    scount = ovf_base + 64'(r[15:0]);
                end else if (r[31:28] == CH4_OVERFLOW && r[19:16] == '0) begin
                    ovf_base += STEP_FOUR_T3;
                end
            end
        end
        res.photon_time = ptime;
        res.sync_count = scount;
        res.channel = ch;
        res.photon_index = ph_ctr;
        if (photon && ph_ctr != '1) ph_ctr++;
        if (rq.end_of_block) ph_ctr = '0;
        return photon;
    endfunction

    function automatic logic [31:0] next_record();
        logic [31:0] r;
        int unsigned pick;
        r = $urandom;
        pick = $urandom_range(0, 99);
        if (dev_kind == DEV_SIX_CH) begin
            if (pick < 65) begin
                r[31] = 1'b0;
            end else if (pick < 85) begin
                r[31] = 1'b1;
                r[30:25] = CH6_OVERFLOW;
                if (pick < 70) r[24:0] = '0;
                else if (pick < 75) r[24:0] = 25'($urandom_range(1, 3));
            end
        end else begin
            if (pick < 65) begin
                r[31:28] = 4'($urandom_range(tag_mode == TAG_T3 ? 1 : 0, 4));
            end else if (pick < 85) begin
                r[31:28] = CH4_OVERFLOW;
                if (pick < 78) begin
                    r[19:16] = '0;
                    r[3:0] = '0;
                end
            end
        end
        return r;
    endfunction

    function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        plan.push_back(r);
    endfunction

    function automatic void row_rec(input logic [31:0] rec, input logic eob);
        t_row r;
        r = '0;
        r.req.record = rec;
        r.req.end_of_block = eob;
        plan.push_back(r);
    endfunction

    function automatic void row_chk(input logic [31:0] rec, input logic eob,
                                    input logic [63:0] ptime, input logic [63:0] scount,
                                    input logic [5:0] ch, input logic [31:0] pidx);
        t_row r;
        r = '0;
        r.req.record = rec;
        r.req.end_of_block = eob;
        r.typed = 1'b1;
        r.want.photon_time = ptime;
        r.want.sync_count = scount;
        r.want.channel = ch;
        r.want.photon_index = pidx;
        plan.push_back(r);
    endfunction

    // acceptance is judged at the falling edge, where everything is settled
    always @(negedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fire) begin
            if (decode_record(i_in_req, predicted))
                photons_due.push_back(req_typed ? req_want : predicted);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_res;
            if (photons_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                want = photons_due.pop_front();
                if (want.photon_time !== got.photon_time) begin
                    mismatches++;
                    $display("%0t: photon_time expected %h actual %h",
                             $time, want.photon_time, got.photon_time);
                end
                if (want.sync_count !== got.sync_count) begin
                    mismatches++;
                    $display("%0t: sync_count expected %h actual %h",
                             $time, want.sync_count, got.sync_count);
                end
                if (want.channel !== got.channel) begin
                    mismatches++;
                    $display("%0t: channel expected %0d actual %0d",
                             $time, want.channel, got.channel);
                end
                if (want.photon_index !== got.photon_index) begin
                    mismatches++;
                    $display("%0t: photon_index expected %0d actual %0d",
                             $time, want.photon_index, got.photon_index);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            stall_tick <= stall_tick + 1'b1;
            case (stall_tick[9:8])
                2'd0: i_out_stall <= 1'b0;
                2'd1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2'd2: i_out_stall <= 1'($urandom_range(0, 1));
                default: i_out_stall <= (stall_tick[3:0] < 4'd11);
            endcase
        end
    end

    task automatic push_record(input t_req rq, input bit typed, input t_res tv);
        if (gaps_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left != 0) burst_left--;
        i_in_valid <= 1'b1;
        i_in_req <= rq;
        req_typed <= typed;
        req_want <= tv;
        do @(posedge i_clk); while (!in_fire);
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (photons_due.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx == CFG_DEVICE_KIND) dev_kind = val[0];
        else if (idx == CFG_TAG_MODE) tag_mode = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_row        r;
        t_req        rq;
        int unsigned n_items;
        logic        dk;
        logic [1:0]  tm;

        // six-channel format, absolute tags, straight after reset
        row_chk(32'h0000_0000, 1'b0, 64'd0, 64'd0, 6'd0, 32'd0);
        row_chk(32'h7FFF_FFFF, 1'b0, 64'd33554431, 64'd0, 6'd63, 32'd1);
        row_rec(32'hFE00_0000, 1'b0);
        row_chk(32'h0000_0005, 1'b0, 64'd33554437, 64'd0, 6'd0, 32'd2);
        row_rec(32'h8000_0001, 1'b1);
        row_chk(32'h0200_0001, 1'b0, 64'd33554433, 64'd0, 6'd1, 32'd0);
        row_rec(32'hFFFF_FFFF, 1'b0);
        // six-channel format, sync plus micro time
        row_cfg(CFG_TAG_MODE, TAG_T3);
        row_rec(32'h0000_0000, 1'b0);
        row_rec(32'h7FFF_FFFF, 1'b0);
        row_rec(32'hFE00_0000, 1'b0);
        row_rec(32'hFE00_03FF, 1'b0);
        row_rec(32'h8000_0000, 1'b1);
        // four-channel format
        row_cfg(CFG_DEVICE_KIND, 2'(DEV_FOUR_CH));
        row_rec(32'h0000_0000, 1'b0);
        row_rec(32'h1FFF_FFFF, 1'b0);
        row_rec(32'h4000_1234, 1'b0);
        row_rec(32'h5000_0000, 1'b0);
        row_rec(32'hF000_0000, 1'b0);
        row_rec(32'hF001_0000, 1'b0);
        row_cfg(CFG_TAG_MODE, TAG_T2);
        row_rec(32'h0FFF_FFFF, 1'b0);
        row_rec(32'h4000_0001, 1'b1);
        row_rec(32'hF000_0000, 1'b0);
        row_rec(32'hF000_0001, 1'b0);
        row_rec(32'h5000_0000, 1'b1);
        // unused tag modes and spare register indexes
        row_cfg(CFG_TAG_MODE, TAG_UNUSED_0);
        row_rec(32'h0000_0000, 1'b0);
        row_rec(32'hFE00_0000, 1'b1);
        row_cfg(CFG_SPARE_A, 2'd3);
        row_cfg(CFG_SPARE_B, 2'd3);
        row_cfg(CFG_TAG_MODE, TAG_UNUSED_1);
        row_rec(32'h1000_0000, 1'b0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            r = plan[i];
            if (r.is_cfg) begin
                wait_quiet();
                set_register(r.idx, r.data);
            end else begin
                push_record(r.req, r.typed, r.want);
            end
        end

        for (int p = 0; p < 12; p++) begin
            case (p)
                0: begin dk = DEV_SIX_CH;  tm = TAG_T2; end
                1: begin dk = DEV_SIX_CH;  tm = TAG_T3; end
                2: begin dk = DEV_FOUR_CH; tm = TAG_T2; end
                3: begin dk = DEV_FOUR_CH; tm = TAG_T3; end
                default: begin
                    dk = 1'($urandom_range(0, 1));
                    tm = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 1))
                                                     : 2'($urandom_range(2, 3));
                end
            endcase
            wait_quiet();
            set_register(CFG_DEVICE_KIND, 2'(dk));
            set_register(CFG_TAG_MODE, tm);
            gaps_on = (p % 3 != 2);
            n_items = (tm == TAG_T2 || tm == TAG_T3) ? $urandom_range(100, 130) : 20;
            repeat (n_items) begin
                rq.record = next_record();
                rq.end_of_block = ($urandom_range(0, 15) == 0);
                push_record(rq, 1'b0, '0);
            end
        end

        // largest overflows with sparse photons for wide carries
        wait_quiet();
        set_register(CFG_DEVICE_KIND, 2'(DEV_SIX_CH));
        set_register(CFG_TAG_MODE, TAG_T2);
        gaps_on = 1'b1;
        for (int k = 0; k < BIG_OVF_RECORDS; k++) begin
            rq.record = (k % 16 == 15) ? {1'b0, 31'($urandom)} : 32'hFFFF_FFFF;
            rq.end_of_block = (k % 40 == 0);
            push_record(rq, 1'b0, '0);
        end
        repeat (8) begin
            rq.record = {1'b0, 31'($urandom)};
            rq.end_of_block = 1'b0;
            push_record(rq, 1'b0, '0);
        end

        wait_quiet();
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
